FILE: hdl/tcaq_pkg.sv
// shared codes for the two-class age-ordered queue
package tcaq_pkg;

	// command codes
	localparam logic [1:0] CMD_ENQUEUE    = 2'd0;
	localparam logic [1:0] CMD_DEQ_OLDEST = 2'd1;
	localparam logic [1:0] CMD_DEQ_B      = 2'd2;
	localparam logic [1:0] CMD_DEQ_A      = 2'd3;

	// class codes on the request side
	localparam logic [1:0] CLASS_A = 2'd0;
	localparam logic [1:0] CLASS_B = 2'd1;

	// class code on the result side
	localparam logic CLASS_OUT_A = 1'b0;
	localparam logic CLASS_OUT_B = 1'b1;

	// status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_EMPTY     = 2'd1;
	localparam logic [1:0] STS_BAD_CLASS = 2'd2;
	localparam logic [1:0] STS_FULL      = 2'd3;

endpackage

FILE: hdl/tcaq_if.sv
// request and result channel interfaces of the two-class age-ordered queue
interface tcaq_cmd_if #(
	parameter int PAYLOAD_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              command;
	logic [1:0]              item_class;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, command, item_class, payload, input ready);
	modport sink   (input valid, command, item_class, payload, output ready);
endinterface

interface tcaq_res_if #(
	parameter int PAYLOAD_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [PAYLOAD_BITS-1:0] payload_out;
	logic                    class_out;
	logic                    all_empty;
	logic                    class_b_empty;
	logic                    class_a_empty;

	modport source (output valid, status, payload_out, class_out, all_empty,
		class_b_empty, class_a_empty, input ready);
	modport sink   (input valid, status, payload_out, class_out, all_empty,
		class_b_empty, class_a_empty, output ready);
endinterface

FILE: hdl/tcaq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module tcaq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: hdl/two_class_age_ordered_queue.sv
// two-class age-ordered queue: top level
// Holds two FIFOs, class A and class B, each QUEUE_DEPTH entries deep, in
// two RAMs. Every entry carries a payload handle and an arrival stamp from
// a shared counter that steps on each successful enqueue.
// Request channel (cmd): command, item_class, payload. Commands are enqueue
// to a class, dequeue the oldest entry of either class (tie goes to class
// B), dequeue class B and dequeue class A.
// Result channel (res): exactly one result per request, with status, the
// dequeued payload and its class (zero when nothing left the queue) and the
// empty flags as they stand after the request.
// Timing: a request is taken in the idle cycle, the RAMs read both heads in
// that cycle, and the next cycle decides; once the output register is free,
// it writes back and loads the result register. A new request is taken only
// after the previous one has been written back, since each read-modify-write
// needs the registered RAM read ahead of it.
// When the receiver stalls, the finished result waits in the output
// register; the next request is still taken, and its result waits in the
// decide cycle until the output register frees up.
// Reset empties both queues and clears the stamp counter; RAM contents are
// left as they are, since only entries between head and tail are ever used.
module two_class_age_ordered_queue #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 16,
	parameter int STAMP_BITS   = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	tcaq_cmd_if.sink   cmd,
	tcaq_res_if.source res
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int ENT_W = PAYLOAD_BITS + STAMP_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	// request captured at acceptance
	logic [1:0]              command_s1;
	logic [1:0]              item_class_s1;
	logic [PAYLOAD_BITS-1:0] payload_s1;

	// queue pointers: index plus lap bit
	logic [IDX_W-1:0] a_head_q, a_tail_q, b_head_q, b_tail_q;
	logic             a_head_lap_q, a_tail_lap_q, b_head_lap_q, b_tail_lap_q;
	logic [STAMP_BITS-1:0] arrival_q;

	// result register
	logic                    res_valid_q;
	logic [1:0]              status_q;
	logic [PAYLOAD_BITS-1:0] payload_out_q;
	logic                    class_out_q;
	logic                    a_empty_q, b_empty_q;

	logic [ENT_W-1:0] a_rd_data, b_rd_data, wr_data;
	logic             a_wr_en, b_wr_en;

	logic a_empty, b_empty, a_full, b_full;
	logic enq_a, enq_b, deq_a, deq_b;
	logic [1:0] status_c;
	logic a_older;
	logic [STAMP_BITS-1:0] stamp_diff;
	logic fire;

	logic [IDX_W-1:0] a_head_nxt, a_tail_nxt, b_head_nxt, b_tail_nxt;
	logic             a_head_lap_nxt, a_tail_lap_nxt, b_head_lap_nxt, b_tail_lap_nxt;
	logic             a_empty_after, b_empty_after;
	logic [PAYLOAD_BITS-1:0] payload_out_c;
	logic                    class_out_c;

	assign cmd.ready = (state_q == ST_IDLE);
	assign fire      = (state_q == ST_EXEC) && (!res_valid_q || res.ready);

	// head entries of both classes, read while idle
	tcaq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram_a (
		.clk     (clk),
		.wr_en   (a_wr_en),
		.wr_addr (a_tail_q),
		.wr_data (wr_data),
		.rd_addr (a_head_q),
		.rd_data (a_rd_data)
	);

	tcaq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram_b (
		.clk     (clk),
		.wr_en   (b_wr_en),
		.wr_addr (b_tail_q),
		.wr_data (wr_data),
		.rd_addr (b_head_q),
		.rd_data (b_rd_data)
	);

	// occupancy from pointers
	assign a_empty = (a_head_q == a_tail_q) && (a_head_lap_q == a_tail_lap_q);
	assign b_empty = (b_head_q == b_tail_q) && (b_head_lap_q == b_tail_lap_q);
	assign a_full  = (a_head_q == a_tail_q) && (a_head_lap_q != a_tail_lap_q);
	assign b_full  = (b_head_q == b_tail_q) && (b_head_lap_q != b_tail_lap_q);

	// wrap-safe age compare of the two head stamps
	assign stamp_diff = a_rd_data[STAMP_BITS-1:0] - b_rd_data[STAMP_BITS-1:0];
	assign a_older    = stamp_diff[STAMP_BITS-1];

	// decode the request
	always_comb begin
		enq_a    = 1'b0;
		enq_b    = 1'b0;
		deq_a    = 1'b0;
		deq_b    = 1'b0;
		status_c = tcaq_pkg::STS_OK;
		case (command_s1)
			tcaq_pkg::CMD_ENQUEUE: begin
				if (item_class_s1 == tcaq_pkg::CLASS_A) begin
					if (a_full) status_c = tcaq_pkg::STS_FULL;
					else enq_a = 1'b1;
				end else if (item_class_s1 == tcaq_pkg::CLASS_B) begin
					if (b_full) status_c = tcaq_pkg::STS_FULL;
					else enq_b = 1'b1;
				end else begin
					status_c = tcaq_pkg::STS_BAD_CLASS;
				end
			end
			tcaq_pkg::CMD_DEQ_OLDEST: begin
				if (!a_empty && !b_empty) begin
					deq_a = a_older;
					deq_b = !a_older;
				end else if (!a_empty) begin
					deq_a = 1'b1;
				end else if (!b_empty) begin
					deq_b = 1'b1;
				end else begin
					status_c = tcaq_pkg::STS_EMPTY;
				end
			end
			tcaq_pkg::CMD_DEQ_B: begin
				if (b_empty) status_c = tcaq_pkg::STS_EMPTY;
				else deq_b = 1'b1;
			end
			tcaq_pkg::CMD_DEQ_A: begin
				if (a_empty) status_c = tcaq_pkg::STS_EMPTY;
				else deq_a = 1'b1;
			end
			default: status_c = tcaq_pkg::STS_EMPTY;
		endcase
	end

	// ram write of a new entry
	assign wr_data = {payload_s1, arrival_q};
	assign a_wr_en = fire && enq_a;
	assign b_wr_en = fire && enq_b;

	// pointer advance with lap toggle at wrap
	always_comb begin
		a_head_nxt     = a_head_q;
		a_head_lap_nxt = a_head_lap_q;
		a_tail_nxt     = a_tail_q;
		a_tail_lap_nxt = a_tail_lap_q;
		b_head_nxt     = b_head_q;
		b_head_lap_nxt = b_head_lap_q;
		b_tail_nxt     = b_tail_q;
		b_tail_lap_nxt = b_tail_lap_q;
		if (deq_a) begin
			a_head_nxt     = (a_head_q == LAST_IDX) ? '0 : a_head_q + 1'b1;
			a_head_lap_nxt = a_head_lap_q ^ (a_head_q == LAST_IDX);
		end
		if (enq_a) begin
			a_tail_nxt     = (a_tail_q == LAST_IDX) ? '0 : a_tail_q + 1'b1;
			a_tail_lap_nxt = a_tail_lap_q ^ (a_tail_q == LAST_IDX);
		end
		if (deq_b) begin
			b_head_nxt     = (b_head_q == LAST_IDX) ? '0 : b_head_q + 1'b1;
			b_head_lap_nxt = b_head_lap_q ^ (b_head_q == LAST_IDX);
		end
		if (enq_b) begin
			b_tail_nxt     = (b_tail_q == LAST_IDX) ? '0 : b_tail_q + 1'b1;
			b_tail_lap_nxt = b_tail_lap_q ^ (b_tail_q == LAST_IDX);
		end
	end

	assign a_empty_after = (a_head_nxt == a_tail_nxt) && (a_head_lap_nxt == a_tail_lap_nxt);
	assign b_empty_after = (b_head_nxt == b_tail_nxt) && (b_head_lap_nxt == b_tail_lap_nxt);

	// dequeued handle and class, zero when nothing leaves
	always_comb begin
		payload_out_c = '0;
		class_out_c   = tcaq_pkg::CLASS_OUT_A;
		if (deq_a) begin
			payload_out_c = a_rd_data[ENT_W-1:STAMP_BITS];
		end else if (deq_b) begin
			payload_out_c = b_rd_data[ENT_W-1:STAMP_BITS];
			class_out_c   = tcaq_pkg::CLASS_OUT_B;
		end
	end

	// control: sequencer, pointers, counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			a_head_q     <= '0;
			a_tail_q     <= '0;
			b_head_q     <= '0;
			b_tail_q     <= '0;
			a_head_lap_q <= 1'b0;
			a_tail_lap_q <= 1'b0;
			b_head_lap_q <= 1'b0;
			b_tail_lap_q <= 1'b0;
			arrival_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				state_q <= ST_EXEC;
			end else if (fire) begin
				state_q <= ST_IDLE;
			end
			if (fire) begin
				a_head_q     <= a_head_nxt;
				a_tail_q     <= a_tail_nxt;
				b_head_q     <= b_head_nxt;
				b_tail_q     <= b_tail_nxt;
				a_head_lap_q <= a_head_lap_nxt;
				a_tail_lap_q <= a_tail_lap_nxt;
				b_head_lap_q <= b_head_lap_nxt;
				b_tail_lap_q <= b_tail_lap_nxt;
				if (enq_a || enq_b) begin
					arrival_q <= arrival_q + 1'b1;
				end
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1    <= cmd.command;
			item_class_s1 <= cmd.item_class;
			payload_s1    <= cmd.payload;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_c;
			payload_out_q <= payload_out_c;
			class_out_q   <= class_out_c;
			a_empty_q     <= a_empty_after;
			b_empty_q     <= b_empty_after;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = status_q;
	assign res.payload_out   = payload_out_q;
	assign res.class_out     = class_out_q;
	assign res.all_empty     = a_empty_q && b_empty_q;
	assign res.class_b_empty = b_empty_q;
	assign res.class_a_empty = a_empty_q;

endmodule

FILE: hdl/tcaq_checker.sv
// port-level checks for the two-class age-ordered queue, with bind
module tcaq_checker #(
	parameter int PAYLOAD_BITS = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic [1:0]              status,
	input logic [PAYLOAD_BITS-1:0] payload_out,
	input logic                    class_out,
	input logic                    all_empty,
	input logic                    class_b_empty,
	input logic                    class_a_empty
);

	// combined empty flag agrees with the two class flags
	a_all_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (all_empty == (class_a_empty && class_b_empty)))
		else $error("all_empty disagrees with class flags");

	// a result with status bad class or full carries no handle and no class
	a_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != tcaq_pkg::STS_OK && status != tcaq_pkg::STS_EMPTY)
		|-> (payload_out == '0 && class_out == tcaq_pkg::CLASS_OUT_A))
		else $error("handle reported on a failed request");

	// a full queue cannot leave both queues empty
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == tcaq_pkg::STS_FULL) |-> !all_empty)
		else $error("full status with all queues empty");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(status)
			&& $stable(payload_out) && $stable(class_out)))
		else $error("stalled result changed");

endmodule

bind two_class_age_ordered_queue tcaq_checker #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_tcaq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.status        (res.status),
	.payload_out   (res.payload_out),
	.class_out     (res.class_out),
	.all_empty     (res.all_empty),
	.class_b_empty (res.class_b_empty),
	.class_a_empty (res.class_a_empty)
);

FILE: tb/tb.sv
// self-checking testbench for the two-class age-ordered queue
`timescale 1ns / 100ps

module tb;

	localparam int DEPTH      = 16;
	localparam int PAYLOAD_W  = 16;
	localparam int STAMP_W    = 32;
	localparam int PTR_W      = $clog2(DEPTH) + 1;
	localparam int RANDOM_REQ = 1350;
	localparam int CYCLE_CAP  = 200000;
	localparam int SETTLE     = 10;

	typedef enum logic [1:0] {
		FILL_PHASE,
		DRAIN_PHASE,
		MIXED_PHASE
	} phase_kind_t;

	typedef struct packed {
		logic [1:0]           command;
		logic [1:0]           item_class;
		logic [PAYLOAD_W-1:0] payload;
		logic                 drain_first;
	} queue_request_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [PAYLOAD_W-1:0] payload_out;
		logic                 class_out;
		logic                 all_empty;
		logic                 class_b_empty;
		logic                 class_a_empty;
	} queue_outcome_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] handle;
		logic [STAMP_W-1:0]   stamp;
	} entry_t;

	logic clk = 1'b0;
	logic arst_n;

	tcaq_cmd_if #(.PAYLOAD_BITS(PAYLOAD_W)) cmd_ch ();
	tcaq_res_if #(.PAYLOAD_BITS(PAYLOAD_W)) res_ch ();

	two_class_age_ordered_queue #(
		.QUEUE_DEPTH (DEPTH),
		.PAYLOAD_BITS(PAYLOAD_W),
		.STAMP_BITS  (STAMP_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of both queues and the stamp counter
	entry_t             a_slots [DEPTH];
	entry_t             b_slots [DEPTH];
	logic [PTR_W-1:0]   a_rd, a_wr, b_rd, b_wr;
	logic [STAMP_W-1:0] next_stamp;

	queue_request_t pending_requests [$];
	queue_outcome_t outcomes_due [$];
	int             requests_taken;
	int             results_seen;
	int             mismatches;
	int             cycle_count = 0;

	// apply one request to the shadow queues and return what the block must answer
	function automatic queue_outcome_t age_queue_outcome(logic [1:0] op, logic [1:0] cls,
		logic [PAYLOAD_W-1:0] handle);
		queue_outcome_t   o;
		logic [PTR_W-1:0] a_fill, b_fill;
		logic [STAMP_W-1:0] age_gap;
		logic             take_any, take_b;
		o.status      = tcaq_pkg::STS_OK;
		o.payload_out = '0;
		o.class_out   = tcaq_pkg::CLASS_OUT_A;
		a_fill   = a_wr - a_rd;
		b_fill   = b_wr - b_rd;
		take_any = 1'b0;
		take_b   = 1'b0;
		case (op)
			tcaq_pkg::CMD_ENQUEUE: begin
				if (cls == tcaq_pkg::CLASS_A) begin
					if (a_fill >= DEPTH) begin
						o.status = tcaq_pkg::STS_FULL;
					end else begin
						a_slots[a_wr[PTR_W-2:0]] = '{handle: handle, stamp: next_stamp};
						a_wr++;
						next_stamp++;
					end
				end else if (cls == tcaq_pkg::CLASS_B) begin
					if (b_fill >= DEPTH) begin
						o.status = tcaq_pkg::STS_FULL;
					end else begin
						b_slots[b_wr[PTR_W-2:0]] = '{handle: handle, stamp: next_stamp};
						b_wr++;
						next_stamp++;
					end
				end else begin
					o.status = tcaq_pkg::STS_BAD_CLASS;
				end
			end
			tcaq_pkg::CMD_DEQ_OLDEST: begin
				// wrap-safe age compare, a tie goes to class B
				if (a_fill != 0 && b_fill != 0) begin
					age_gap  = a_slots[a_rd[PTR_W-2:0]].stamp - b_slots[b_rd[PTR_W-2:0]].stamp;
					take_any = 1'b1;
					take_b   = !age_gap[STAMP_W-1];
				end else if (a_fill != 0) begin
					take_any = 1'b1;
				end else if (b_fill != 0) begin
					take_any = 1'b1;
					take_b   = 1'b1;
				end
			end
			tcaq_pkg::CMD_DEQ_B: begin
				take_any = (b_fill != 0);
				take_b   = 1'b1;
			end
			tcaq_pkg::CMD_DEQ_A: begin
				take_any = (a_fill != 0);
			end
			default: begin
				take_any = 1'b0;
			end
		endcase
		// pop the chosen head
		if (op != tcaq_pkg::CMD_ENQUEUE) begin
			if (!take_any) begin
				o.status = tcaq_pkg::STS_EMPTY;
			end else if (take_b) begin
				o.payload_out = b_slots[b_rd[PTR_W-2:0]].handle;
				o.class_out   = tcaq_pkg::CLASS_OUT_B;
				b_rd++;
			end else begin
				o.payload_out = a_slots[a_rd[PTR_W-2:0]].handle;
				o.class_out   = tcaq_pkg::CLASS_OUT_A;
				a_rd++;
			end
		end
		o.class_a_empty = (a_wr == a_rd);
		o.class_b_empty = (b_wr == b_rd);
		o.all_empty     = o.class_a_empty && o.class_b_empty;
		return o;
	endfunction

	task automatic queue_up(logic [1:0] op, logic [1:0] cls, logic [PAYLOAD_W-1:0] handle,
		logic drain_first);
		queue_request_t r;
		r.command     = op;
		r.item_class  = cls;
		r.payload     = handle;
		r.drain_first = drain_first;
		pending_requests.push_back(r);
	endtask

	// request driver: predicts each accepted request, then offers the next one
	always @(posedge clk or negedge arst_n) begin : request_driver
		queue_request_t nxt;
		logic           offer;
		logic           calm;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			requests_taken = 0;
			a_rd       = '0;
			a_wr       = '0;
			b_rd       = '0;
			b_wr       = '0;
			next_stamp = '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				outcomes_due.push_back(age_queue_outcome(cmd_ch.command, cmd_ch.item_class,
					cmd_ch.payload));
				requests_taken++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				calm  = (requests_taken >= 500 && requests_taken < 750);
				offer = 1'b0;
				if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
					if (!pending_requests[0].drain_first || outcomes_due.size() == 0) begin
						nxt   = pending_requests.pop_front();
						offer = 1'b1;
					end
				end
				cmd_ch.valid <= offer;
				if (offer) begin
					cmd_ch.command    <= nxt.command;
					cmd_ch.item_class <= nxt.item_class;
					cmd_ch.payload    <= nxt.payload;
				end
			end
		end
	end

	// result monitor: field by field against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_monitor
		queue_outcome_t want;
		logic           calm;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			results_seen = 0;
			mismatches   = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (outcomes_due.size() == 0) begin
					$error("result arrived with no request outstanding");
					mismatches++;
				end else begin
					want = outcomes_due.pop_front();
					if (res_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res_ch.status);
						mismatches++;
					end
					if (res_ch.payload_out !== want.payload_out) begin
						$error("payload_out: expected %h, got %h", want.payload_out,
							res_ch.payload_out);
						mismatches++;
					end
					if (res_ch.class_out !== want.class_out) begin
						$error("class_out: expected %0d, got %0d", want.class_out,
							res_ch.class_out);
						mismatches++;
					end
					if (res_ch.all_empty !== want.all_empty) begin
						$error("all_empty: expected %0d, got %0d", want.all_empty,
							res_ch.all_empty);
						mismatches++;
					end
					if (res_ch.class_b_empty !== want.class_b_empty) begin
						$error("class_b_empty: expected %0d, got %0d", want.class_b_empty,
							res_ch.class_b_empty);
						mismatches++;
					end
					if (res_ch.class_a_empty !== want.class_a_empty) begin
						$error("class_a_empty: expected %0d, got %0d", want.class_a_empty,
							res_ch.class_a_empty);
						mismatches++;
					end
				end
			end
			calm = (results_seen >= 500 && results_seen < 750);
			res_ch.ready <= calm || ($urandom_range(99) >= 22);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("two_class_age_ordered_queue test failed");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin : stimulus
		phase_kind_t          phase;
		logic [1:0]           favoured;
		logic [1:0]           cls;
		logic [1:0]           op;
		logic [PAYLOAD_W-1:0] handle;
		int                   phase_len;
		int                   enq_pct;
		int                   roll;
		int                   random_count;
		logic                 drain_first;

		arst_n = 1'b0;

		// directed: empty dequeues, bad classes, age ordering, payload extremes
		queue_up(tcaq_pkg::CMD_DEQ_OLDEST, 2'd3, 16'hFFFF, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_A, 2'd2, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_B, tcaq_pkg::CLASS_B, 16'h1234, 1'b0);
		queue_up(tcaq_pkg::CMD_ENQUEUE, 2'd2, 16'hFFFF, 1'b0);
		queue_up(tcaq_pkg::CMD_ENQUEUE, 2'd3, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_ENQUEUE, tcaq_pkg::CLASS_A, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_ENQUEUE, tcaq_pkg::CLASS_B, 16'hFFFF, 1'b0);
		queue_up(tcaq_pkg::CMD_ENQUEUE, tcaq_pkg::CLASS_A, 16'h8000, 1'b0);
		queue_up(tcaq_pkg::CMD_ENQUEUE, tcaq_pkg::CLASS_B, 16'h0001, 1'b0);
		queue_up(tcaq_pkg::CMD_ENQUEUE, tcaq_pkg::CLASS_B, 16'h5555, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_OLDEST, tcaq_pkg::CLASS_B, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_OLDEST, 2'd2, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_B, tcaq_pkg::CLASS_A, 16'hFFFF, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_OLDEST, 2'd3, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_A, tcaq_pkg::CLASS_B, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_OLDEST, tcaq_pkg::CLASS_A, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_OLDEST, tcaq_pkg::CLASS_A, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_ENQUEUE, tcaq_pkg::CLASS_A, 16'hAAAA, 1'b1);
		queue_up(tcaq_pkg::CMD_DEQ_B, 2'd3, 16'h0000, 1'b0);
		queue_up(tcaq_pkg::CMD_DEQ_OLDEST, tcaq_pkg::CLASS_B, 16'h0000, 1'b0);

		// random phases: filling phases lean on one class so that it runs full
		random_count = 0;
		while (random_count < RANDOM_REQ) begin
			phase     = phase_kind_t'($urandom_range(2, 0));
			phase_len = $urandom_range(60, 30);
			favoured  = $urandom_range(1, 0) ? tcaq_pkg::CLASS_B : tcaq_pkg::CLASS_A;
			enq_pct   = (phase == FILL_PHASE) ? 80 : (phase == DRAIN_PHASE) ? 20 : 50;
			drain_first = (random_count == 0) || ($urandom_range(5) == 0);
			for (int i = 0; i < phase_len; i++) begin
				handle = PAYLOAD_W'($urandom);
				roll   = $urandom_range(99);
				if (roll < enq_pct) begin
					op   = tcaq_pkg::CMD_ENQUEUE;
					roll = $urandom_range(99);
					if (roll < 8)
						cls = 2'($urandom_range(3, 2));
					else if (roll < 70)
						cls = favoured;
					else
						cls = (favoured == tcaq_pkg::CLASS_A) ? tcaq_pkg::CLASS_B
							: tcaq_pkg::CLASS_A;
				end else begin
					roll = $urandom_range(99);
					op   = (roll < 50) ? tcaq_pkg::CMD_DEQ_OLDEST
						: (roll < 75) ? tcaq_pkg::CMD_DEQ_A : tcaq_pkg::CMD_DEQ_B;
					cls  = 2'($urandom_range(3, 0));
				end
				queue_up(op, cls, handle, drain_first && i == 0);
				random_count++;
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// let everything through, then allow for stray results
		while (pending_requests.size() != 0 || cmd_ch.valid)
			@(posedge clk);
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0) begin
			$display("two_class_age_ordered_queue test passed");
		end else begin
			$display("two_class_age_ordered_queue test failed");
		end
		$finish;
	end

endmodule
